>>> sv/avlt_pkg.sv
// Types, character codes and helpers shared by the attribute/value line tokenizer
package avlt_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [5:0] ATTR_MAX_RESET = 6'd31;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

    localparam logic [1:0] ROLE_IGNORED   = 2'd0;
    localparam logic [1:0] ROLE_ATTR_KEPT = 2'd1;
    localparam logic [1:0] ROLE_ATTR_TRUNC = 2'd2;
    localparam logic [1:0] ROLE_VALUE     = 2'd3;

    typedef enum logic [2:0] {
        PH_BETWEEN    = 3'd0,
        PH_ATTR       = 3'd1,
        PH_AFTER_ATTR = 3'd2,
        PH_EQ         = 3'd3,
        PH_BARE       = 3'd4,
        PH_QUOTED     = 3'd5,
        PH_COMMENT    = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [5:0] attr_len;
        logic [7:0] tuples;
    } t_state;

    typedef struct packed {
        logic [1:0] role;
        logic       tuple_end;
        logic       tuple_has_value;
        logic       line_end;
        logic [7:0] tuple_count;
    } t_result;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

>>> sv/attr_value_line_tokenizer.sv
// Top level: input register, per-byte classifier and result register of the line tokenizer
// A byte in the input register moves to the result register when that one is empty or being read.
// One byte per cycle unless stalled; parse state updates as each byte enters the result register.
// Output stall holds the result register, then the input register, then deasserts o_in_ready.
// Reset (i_rst_n low, synchronous) empties both registers, sets the phase to between tuples,
// clears the attribute length and tuple count, and sets the attribute cap to 31.
module attr_value_line_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_role,
    output logic       o_tuple_end,
    output logic       o_tuple_has_value,
    output logic       o_line_end,
    output logic [7:0] o_tuple_count
);
    import avlt_pkg::*;

    logic [5:0] r_attr_max_len;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    n_out;
    logic       advance;

    avlt_step u_step (
        .i_byte     (r_in_byte),
        .i_attr_max (r_attr_max_len),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_max_len <= ATTR_MAX_RESET;
        end else if (i_cfg_we) begin
            r_attr_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_state.phase  <= PH_BETWEEN;
            r_state.attr_len <= '0;
            r_state.tuples <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out      <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_role            = r_out.role;
    assign o_tuple_end       = r_out.tuple_end;
    assign o_tuple_has_value = r_out.tuple_has_value;
    assign o_line_end        = r_out.line_end;
    assign o_tuple_count     = r_out.tuple_count;

    a_count_only_at_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_line_end) |-> (o_tuple_count == 8'd0))
        else $error("tuple count without line end");

    a_value_only_at_tuple_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tuple_has_value) |-> o_tuple_end)
        else $error("has-value flag without tuple end");

    a_newline_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_end) |-> (o_role == ROLE_IGNORED && o_out_byte == CH_NL))
        else $error("line end on a byte that is not an ignored newline");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !r_in_valid) |=> !o_out_valid)
        else $error("result repeated after transaction");

endmodule

>>> sv/avlt_step.sv
// Per-byte classifier: next parse state and result fields from current state and byte
module avlt_step (
    input  logic [7:0]       i_byte,
    input  logic [5:0]       i_attr_max,
    input  avlt_pkg::t_state i_state,
    output avlt_pkg::t_state o_state,
    output avlt_pkg::t_result o_result
);
    import avlt_pkg::*;

    logic       attr_fits;
    logic [5:0] attr_len_inc;
    logic [1:0] attr_role;
    logic [5:0] attr_len_next;
    logic       tend;
    logic       tval;
    logic [1:0] role;
    t_phase     phase_next;
    logic [5:0] len_next;
    logic [7:0] tuples_inc;

    assign attr_fits     = i_state.attr_len < i_attr_max;
    assign attr_len_inc  = i_state.attr_len + 6'd1;
    assign attr_role     = attr_fits ? ROLE_ATTR_KEPT : ROLE_ATTR_TRUNC;
    assign attr_len_next = attr_fits ? attr_len_inc : i_state.attr_len;

    always_comb begin
        tend       = 1'b0;
        tval       = 1'b0;
        role       = ROLE_IGNORED;
        phase_next = i_state.phase;
        len_next   = i_state.attr_len;
        if (i_byte == CH_NL) begin
            case (i_state.phase)
                PH_ATTR, PH_AFTER_ATTR: begin
                    tend = 1'b1;
                end
                PH_EQ, PH_BARE, PH_QUOTED: begin
                    tend = 1'b1;
                    tval = 1'b1;
                end
                default: begin
                end
            endcase
            phase_next = PH_BETWEEN;
            len_next   = '0;
        end else begin
            case (i_state.phase)
                PH_ATTR: begin
                    if (i_byte == CH_EQ) begin
                        phase_next = PH_EQ;
                    end else if (is_white(i_byte)) begin
                        phase_next = PH_AFTER_ATTR;
                    end else begin
                        role     = attr_role;
                        len_next = attr_len_next;
                    end
                end
                PH_AFTER_ATTR: begin
                    if (is_white(i_byte)) begin
                        phase_next = PH_AFTER_ATTR;
                    end else if (i_byte == CH_EQ) begin
                        phase_next = PH_EQ;
                    end else begin
                        tend = 1'b1;
                        if (i_byte == CH_HASH) begin
                            phase_next = PH_COMMENT;
                        end else begin
                            // new tuple starts on this byte; length restarts at zero
                            len_next = '0;
                            if (i_byte == CH_EQ) begin
                                phase_next = PH_EQ;
                            end else begin
                                phase_next = PH_ATTR;
                                role       = (i_attr_max != 6'd0) ? ROLE_ATTR_KEPT
                                                                  : ROLE_ATTR_TRUNC;
                                len_next   = (i_attr_max != 6'd0) ? 6'd1 : 6'd0;
                            end
                        end
                    end
                end
                PH_EQ: begin
                    if (i_byte == CH_QUOTE) begin
                        phase_next = PH_QUOTED;
                    end else if (i_byte == CH_HASH) begin
                        tend       = 1'b1;
                        tval       = 1'b1;
                        phase_next = PH_COMMENT;
                    end else if (is_white(i_byte)) begin
                        tend       = 1'b1;
                        tval       = 1'b1;
                        phase_next = PH_BETWEEN;
                    end else begin
                        role       = ROLE_VALUE;
                        phase_next = PH_BARE;
                    end
                end
                PH_BARE: begin
                    if (is_white(i_byte)) begin
                        tend       = 1'b1;
                        tval       = 1'b1;
                        phase_next = PH_BETWEEN;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                PH_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        tend       = 1'b1;
                        tval       = 1'b1;
                        phase_next = PH_BETWEEN;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                PH_COMMENT: begin
                    phase_next = PH_COMMENT;
                end
                default: begin
                    if (is_white(i_byte)) begin
                        phase_next = PH_BETWEEN;
                    end else if (i_byte == CH_HASH) begin
                        phase_next = PH_COMMENT;
                    end else begin
                        len_next = '0;
                        if (i_byte == CH_EQ) begin
                            phase_next = PH_EQ;
                        end else begin
                            phase_next = PH_ATTR;
                            role       = (i_attr_max != 6'd0) ? ROLE_ATTR_KEPT
                                                              : ROLE_ATTR_TRUNC;
                            len_next   = (i_attr_max != 6'd0) ? 6'd1 : 6'd0;
                        end
                    end
                end
            endcase
        end
    end

    assign tuples_inc = (tend && (i_state.tuples != COUNT_MAX)) ?
                        i_state.tuples + 8'd1 : i_state.tuples;

    assign o_state.phase    = phase_next;
    assign o_state.attr_len = len_next;
    assign o_state.tuples   = (i_byte == CH_NL) ? 8'd0 : tuples_inc;

    assign o_result.role            = role;
    assign o_result.tuple_end       = tend;
    assign o_result.tuple_has_value = tval;
    assign o_result.line_end        = (i_byte == CH_NL);
    assign o_result.tuple_count     = (i_byte == CH_NL) ? tuples_inc : 8'd0;

endmodule

>>> bench/attr_value_line_tokenizer_tb.sv
// Self-checking testbench for the attribute/value line tokenizer, with random idling on both sides
`timescale 1ns / 1ps

module attr_value_line_tokenizer_tb;
    import avlt_pkg::*;

    localparam logic [3:0] BAN_BLANK = 4'b0001;
    localparam logic [3:0] BAN_EQ    = 4'b0010;
    localparam logic [3:0] BAN_HASH  = 4'b0100;
    localparam logic [3:0] BAN_QUOTE = 4'b1000;

    typedef struct packed {
        logic [7:0] ch;
        t_result    res;
    } t_token;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic [1:0] o_role;
    logic       o_tuple_end;
    logic       o_tuple_has_value;
    logic       o_line_end;
    logic [7:0] o_tuple_count;

    t_phase     parse_state = PH_BETWEEN;
    logic [5:0] kept_len    = '0;
    logic [7:0] line_tuples = '0;
    logic [5:0] attr_cap    = ATTR_MAX_RESET;

    t_token     pending_tokens[$];
    int         fail_count  = 0;
    int         items_sent  = 0;
    bit         in_quiet    = 1'b0;
    bit         out_quiet   = 1'b0;

    attr_value_line_tokenizer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_role            (o_role),
        .o_tuple_end       (o_tuple_end),
        .o_tuple_has_value (o_tuple_has_value),
        .o_line_end        (o_line_end),
        .o_tuple_count     (o_tuple_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic [1:0] take_attr_char();
        if (kept_len < attr_cap) begin
            kept_len = kept_len + 6'd1;
            return ROLE_ATTR_KEPT;
        end
        return ROLE_ATTR_TRUNC;
    endfunction

    function automatic logic [1:0] open_tuple(input logic [7:0] c);
        kept_len = '0;
        if (c == CH_EQ) begin
            parse_state = PH_EQ;
            return ROLE_IGNORED;
        end
        parse_state = PH_ATTR;
        return take_attr_char();
    endfunction

    function automatic t_result tokenize_byte(input logic [7:0] c);
        t_result r;
        r = '0;
        if (c == CH_NL) begin
            r.line_end = 1'b1;
            case (parse_state)
                PH_ATTR, PH_AFTER_ATTR: r.tuple_end = 1'b1;
                PH_EQ, PH_BARE, PH_QUOTED: begin
                    r.tuple_end       = 1'b1;
                    r.tuple_has_value = 1'b1;
                end
                default: ;
            endcase
            if (r.tuple_end && line_tuples != COUNT_MAX)
                line_tuples = line_tuples + 8'd1;
            r.tuple_count = line_tuples;
            parse_state   = PH_BETWEEN;
            kept_len      = '0;
            line_tuples   = '0;
            return r;
        end
        case (parse_state)
            PH_ATTR: begin
                if (c == CH_EQ)
                    parse_state = PH_EQ;
                else if (is_blank(c))
                    parse_state = PH_AFTER_ATTR;
                else
                    r.role = take_attr_char();
            end
            PH_AFTER_ATTR: begin
                if (c == CH_EQ) begin
                    parse_state = PH_EQ;
                end else if (!is_blank(c)) begin
                    r.tuple_end = 1'b1;
                    if (c == CH_HASH)
                        parse_state = PH_COMMENT;
                    else
                        r.role = open_tuple(c);
                end
            end
            PH_EQ: begin
                if (c == CH_QUOTE) begin
                    parse_state = PH_QUOTED;
                end else if (c == CH_HASH || is_blank(c)) begin
                    r.tuple_end       = 1'b1;
                    r.tuple_has_value = 1'b1;
                    if (c == CH_HASH)
                        parse_state = PH_COMMENT;
                    else
                        parse_state = PH_BETWEEN;
                end else begin
                    r.role      = ROLE_VALUE;
                    parse_state = PH_BARE;
                end
            end
            PH_BARE: begin
                if (is_blank(c)) begin
                    r.tuple_end       = 1'b1;
                    r.tuple_has_value = 1'b1;
                    parse_state       = PH_BETWEEN;
                end else begin
                    r.role = ROLE_VALUE;
                end
            end
            PH_QUOTED: begin
                if (c == CH_QUOTE) begin
                    r.tuple_end       = 1'b1;
                    r.tuple_has_value = 1'b1;
                    parse_state       = PH_BETWEEN;
                end else begin
                    r.role = ROLE_VALUE;
                end
            end
            PH_COMMENT: ;
            default: begin
                if (is_blank(c))
                    parse_state = PH_BETWEEN;
                else if (c == CH_HASH)
                    parse_state = PH_COMMENT;
                else
                    r.role = open_tuple(c);
            end
        endcase
        if (r.tuple_end && line_tuples != COUNT_MAX)
            line_tuples = line_tuples + 8'd1;
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_attr_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 30);
        return $urandom_range(55, 70);
    endfunction

    function automatic logic [7:0] rand_char(input logic [3:0] ban);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 1) == 1)
                c = 8'($urandom_range(8'h21, 8'h7E));
            else
                c = 8'($urandom_range(0, 255));
        end while (c == CH_NL
                   || ((ban & BAN_BLANK) != 0 && is_blank(c))
                   || ((ban & BAN_EQ) != 0 && c == CH_EQ)
                   || ((ban & BAN_HASH) != 0 && c == CH_HASH)
                   || ((ban & BAN_QUOTE) != 0 && c == CH_QUOTE));
        return c;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected result transaction: out_byte %0d", o_out_byte);
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("out_byte", want.ch, o_out_byte);
                check_field("role", 8'(want.res.role), 8'(o_role));
                check_field("tuple_end", 8'(want.res.tuple_end), 8'(o_tuple_end));
                check_field("tuple_has_value", 8'(want.res.tuple_has_value),
                            8'(o_tuple_has_value));
                check_field("line_end", 8'(want.res.line_end), 8'(o_line_end));
                check_field("tuple_count", want.res.tuple_count, o_tuple_count);
            end
        end
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            stall = pick_gap(out_quiet);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        t_token tok;
        gap = pick_gap(in_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tok.ch  = b;
        tok.res = tokenize_byte(b);
        pending_tokens.push_back(tok);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_TAB);
                default: send_byte(CH_CR);
            endcase
        end
    endtask

    task automatic send_attr(input int n);
        send_byte(rand_char(BAN_BLANK | BAN_EQ | BAN_HASH));
        repeat (n - 1) send_byte(rand_char(BAN_BLANK | BAN_EQ));
    endtask

    task automatic send_value(input logic [3:0] ban);
        repeat ($urandom_range(1, 8)) send_byte(rand_char(ban));
    endtask

    task automatic send_comment_line();
        repeat ($urandom_range(0, 6)) send_byte(rand_char('0));
        send_byte(CH_NL);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [5:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        attr_cap = v;
    endtask

    task automatic send_random_line();
        int tuples;
        int shape;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NL);
            return;
        end
        tuples = $urandom_range(0, 5);
        for (int k = 0; k < tuples; k++) begin
            if (k > 0 || $urandom_range(0, 1) == 1)
                send_blanks($urandom_range(1, 3));
            shape = $urandom_range(0, 7);
            if (shape != 5)
                send_attr(pick_attr_len());
            case (shape)
                0: ;
                1, 5: begin
                    send_byte(CH_EQ);
                    send_value(BAN_BLANK);
                end
                2: begin
                    send_byte(CH_EQ);
                    send_byte(CH_QUOTE);
                    send_value(BAN_QUOTE);
                    send_byte(CH_QUOTE);
                end
                3: send_byte(CH_EQ);
                4: begin
                    send_blanks($urandom_range(1, 2));
                    send_byte(CH_EQ);
                    send_value(BAN_BLANK);
                end
                6: begin
                    send_byte(CH_EQ);
                    send_byte(CH_QUOTE);
                    send_value(BAN_QUOTE);
                    send_byte(CH_NL);
                    return;
                end
                default: begin
                    send_byte(CH_EQ);
                    send_byte(CH_HASH);
                    send_comment_line();
                    return;
                end
            endcase
        end
        case ($urandom_range(0, 2))
            0: send_byte(CH_NL);
            1: begin
                send_blanks($urandom_range(1, 3));
                send_byte(CH_NL);
            end
            default: begin
                send_blanks($urandom_range(1, 2));
                send_byte(CH_HASH);
                send_comment_line();
            end
        endcase
    endtask

    task automatic test_directed_lines();
        send_text("ab c =\t=#q\n");
        send_text("x=\"a\" y=\"b\n");
        send_text("w=a#=\"");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text(" k=\n");
        send_text("#y\n");
    endtask

    task automatic test_attr_cap();
        write_cap(6'd1);
        send_text("abc=d e\n");
        write_cap(6'd63);
        repeat (70) send_byte(rand_char(BAN_BLANK | BAN_EQ | BAN_HASH));
        send_byte(CH_NL);
        write_cap(6'd0);
        send_text("xy z\n");
    endtask

    task automatic test_count_saturation();
        in_quiet = 1'b1;
        repeat (258) send_text("= ");
        send_byte(CH_NL);
        in_quiet = 1'b0;
    endtask

    task automatic test_random_lines();
        int stop_at;
        logic [5:0] caps[5];
        caps = '{6'd63, 6'd1, 6'($urandom_range(2, 62)), 6'($urandom_range(2, 62)),
                 ATTR_MAX_RESET};
        for (int p = 0; p < 5; p++) begin
            write_cap(caps[p]);
            in_quiet  = (p == 0) || (p == 2);
            out_quiet = (p == 0) || (p == 3);
            stop_at   = items_sent + 90;
            while (items_sent < stop_at)
                send_random_line();
        end
        out_quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_byte   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        test_attr_cap();
        test_count_saturation();
        test_random_lines();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS attr_value_line_tokenizer");
        else
            $display("FAIL attr_value_line_tokenizer");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("FAIL attr_value_line_tokenizer");
        $finish;
    end

endmodule
